FILE: rtl/core/rlg_pkg.sv
// Shared types, codes and constants for the region levels and gamma pixel unit.
`timescale 1ns / 1ps
`default_nettype none
package rlg_pkg;

  localparam logic [1:0] MODE_CORRECT  = 2'd0;
  localparam logic [1:0] MODE_SOURCE   = 2'd1;
  localparam logic [1:0] MODE_ESTIMATE = 2'd2;

  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // table entry layout: black, gamma code, white
  localparam logic [23:0] ENTRY_DEFAULT = {8'd0, 8'd127, 8'd255};

  // side data that rides along with every pipeline stage
  typedef struct packed {
    logic        valid;
    logic        forced;
    logic [7:0]  fval;
    logic        degen;
    logic        oor;
    logic [16:0] g;
  } side_t;

  // Q1.30 factor 2^(-2^-step): repeated floored square roots starting at 0.5
  function automatic logic [29:0] exp_factor(input int unsigned step);
    logic [63:0] c;
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bv;
    c = 64'd1 << 29;
    for (int unsigned j = 1; j <= step; j++) begin
      a   = c << 30;
      res = 64'd0;
      bv  = 64'd1 << 62;
      while (bv > a) bv = bv >> 2;
      while (bv != 64'd0) begin
        if (a >= res + bv) begin
          a   = a - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      c = res;
    end
    return c[29:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rlg_div.sv
// Pipelined restoring divider: 16-bit Q0.16 ratio num/den, four bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module rlg_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire rlg_pkg::side_t side_in,
  input  wire logic [7:0]    num,
  input  wire logic [7:0]    den,
  output rlg_pkg::side_t     side_out,
  output logic [15:0]        quot
);

  localparam int STAGES = 4;
  localparam int STEPS  = 4;

  rlg_pkg::side_t sd   [0:STAGES];
  logic [7:0]     rem  [0:STAGES];
  logic [7:0]     dv   [0:STAGES];
  logic [15:0]    q    [0:STAGES];

  assign sd[0]  = side_in;
  assign rem[0] = num;
  assign dv[0]  = den;
  assign q[0]   = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [7:0]  rem_next;
    logic [15:0] q_next;

    always_comb begin
      logic [8:0] t;
      rem_next = rem[s];
      q_next   = q[s];
      for (int i = 0; i < STEPS; i++) begin
        t = {rem_next, 1'b0};
        if (t >= {1'b0, dv[s]}) begin
          rem_next = 8'(t - {1'b0, dv[s]});
          q_next   = {q_next[14:0], 1'b1};
        end else begin
          rem_next = t[7:0];
          q_next   = {q_next[14:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[s+1].valid <= 1'b0;
      end else if (en) begin
        sd[s+1].valid <= sd[s].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[s+1].forced <= sd[s].forced;
        sd[s+1].fval   <= sd[s].fval;
        sd[s+1].degen  <= sd[s].degen;
        sd[s+1].oor    <= sd[s].oor;
        sd[s+1].g      <= sd[s].g;
        rem[s+1]       <= rem_next;
        dv[s+1]        <= dv[s];
        q[s+1]         <= q_next;
      end
    end
  end

  assign side_out = sd[STAGES];
  assign quot     = q[STAGES];

endmodule
`default_nettype wire

FILE: rtl/core/rlg_log.sv
// Pipelined -log2 of a Q0.16 ratio: normalize, sixteen squaring stages, Q.16 result.
`timescale 1ns / 1ps
`default_nettype none
module rlg_log (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire rlg_pkg::side_t side_in,
  input  wire logic [15:0]   ratio,
  output rlg_pkg::side_t     side_out,
  output logic [20:0]        mag
);

  localparam int SQ = 16;

  rlg_pkg::side_t sd   [0:SQ];
  logic [30:0]    x    [0:SQ];
  logic [15:0]    frac [0:SQ];
  logic [3:0]     k    [0:SQ];

  // leading one position and Q1.30 mantissa
  logic [3:0]  k_next;
  logic [15:0] norm;

  always_comb begin
    k_next = '0;
    for (int b = 0; b < 16; b++) begin
      if (ratio[b]) k_next = 4'(b);
    end
    norm = ratio << (4'd15 - k_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else if (en) begin
      sd[0].valid <= side_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0].forced <= side_in.forced;
      sd[0].fval   <= side_in.fval;
      sd[0].degen  <= side_in.degen;
      sd[0].oor    <= side_in.oor;
      sd[0].g      <= side_in.g;
      x[0]         <= {norm, 15'd0};
      frac[0]      <= '0;
      k[0]         <= k_next;
    end
  end

  for (genvar i = 0; i < SQ; i++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] t;

    assign prod = x[i] * x[i];
    assign t    = prod[61:30];

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i+1].valid <= 1'b0;
      end else if (en) begin
        sd[i+1].valid <= sd[i].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1].forced <= sd[i].forced;
        sd[i+1].fval   <= sd[i].fval;
        sd[i+1].degen  <= sd[i].degen;
        sd[i+1].oor    <= sd[i].oor;
        sd[i+1].g      <= sd[i].g;
        k[i+1]         <= k[i];
        // square of at least 2.0: take the bit and renormalize
        if (t[31]) begin
          x[i+1]    <= t[31:1];
          frac[i+1] <= frac[i] | (16'd1 << (15 - i));
        end else begin
          x[i+1]    <= t[30:0];
          frac[i+1] <= frac[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out.valid <= sd[SQ].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out.forced <= sd[SQ].forced;
      side_out.fval   <= sd[SQ].fval;
      side_out.degen  <= sd[SQ].degen;
      side_out.oor    <= sd[SQ].oor;
      side_out.g      <= sd[SQ].g;
      mag             <= {5'd16 - {1'b0, k[SQ]}, 16'd0} - {5'd0, frac[SQ]};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rlg_exp.sv
// Pipelined 255 * 2^(-p) with Q.16 input: sixteen factor stages and the output register.
`timescale 1ns / 1ps
`default_nettype none
module rlg_exp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire rlg_pkg::side_t side_in,
  input  wire logic [20:0]   p,
  output logic               valid,
  output logic [7:0]         pixel,
  output logic               degen,
  output logic               oor
);

  localparam int FS = 16;

  rlg_pkg::side_t sd [0:FS];
  logic [30:0]    y  [0:FS];
  logic [15:0]    f  [0:FS];
  logic [4:0]     ip [0:FS];

  assign sd[0] = side_in;
  assign y[0]  = 31'h4000_0000;
  assign f[0]  = p[15:0];
  assign ip[0] = p[20:16];

  for (genvar i = 0; i < FS; i++) begin : g_fac
    localparam logic [29:0] C = rlg_pkg::exp_factor(i + 1);
    logic [60:0] prod;

    assign prod = y[i] * C;

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i+1].valid <= 1'b0;
      end else if (en) begin
        sd[i+1].valid <= sd[i].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1].forced <= sd[i].forced;
        sd[i+1].fval   <= sd[i].fval;
        sd[i+1].degen  <= sd[i].degen;
        sd[i+1].oor    <= sd[i].oor;
        sd[i+1].g      <= sd[i].g;
        f[i+1]         <= f[i];
        ip[i+1]        <= ip[i];
        y[i+1]         <= f[i][15 - i] ? prod[60:30] : y[i];
      end
    end
  end

  // scale by 255, drop the Q1.30 point, then the integer part of the exponent
  logic [38:0] scaled;
  logic [8:0]  shifted;
  logic [7:0]  pix_next;

  assign scaled  = {y[FS], 8'd0} - {8'd0, y[FS]};
  assign shifted = scaled[38:30] >> ip[FS];

  always_comb begin
    if (sd[FS].forced) begin
      pix_next = sd[FS].fval;
    end else if (shifted[8]) begin
      pix_next = 8'd255;
    end else begin
      pix_next = shifted[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= sd[FS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel <= pix_next;
      degen <= sd[FS].degen;
      oor   <= sd[FS].oor;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/region_levels_gamma_pixel_unit.sv
// Top level: region table, level setup, log/exp gamma pipeline and output beat.
//
// Usage: the input channel (in_valid / in_stall) carries one beat per item: either a
// process item (operation 0) with a source byte, an estimate byte and a region label,
// or a table write (operation 1) that loads black, gamma code and white for one entry.
// A process item gives exactly one output beat (pixel_out and two flags) on the
// output channel (out_valid / out_stall); a write item gives none.
// Throughput: one item per clock unless out_stall or the table clearing holds the input.
// The path holds the 16-stage squaring log2 pipeline, the 16-stage exp2 factor
// pipeline and a 4-stage divider; each stage holds one multiply or four divide steps.
// Reset: output_mode returns to corrected, all stages empty, then a clearing pass
// loads every table entry with black 0, gamma code 127, white 255; the
// input is stalled during that pass, configuration writes are taken as ever.
// When the receiver stalls with a beat waiting, the whole pipeline holds and in_stall
// rises; nothing is lost or repeated. Write output_mode (cfg_we/cfg_wdata) only while
// the block is empty.
`timescale 1ns / 1ps
`default_nettype none
module region_levels_gamma_pixel_unit #(
  parameter int REGIONS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [7:0]  source_pixel,
  input  wire logic [7:0]  estimate_pixel,
  input  wire logic [15:0] region_label,
  input  wire logic [7:0]  entry_index,
  input  wire logic [7:0]  entry_black,
  input  wire logic [7:0]  entry_gamma_code,
  input  wire logic [7:0]  entry_white,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       pixel_out,
  output logic             degenerate_levels,
  output logic             label_out_of_range
);

  localparam int AW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  logic [1:0]    mode;
  logic          adv;
  logic          accept;
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv || clr_busy;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= rlg_pkg::MODE_CORRECT;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // clearing pass over the table after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(REGIONS - 1)) clr_busy <= 1'b0;
    end
  end

  // region table
  logic [23:0]   table_mem [0:REGIONS-1];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [23:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [23:0]   rd_data;

  assign wr_en   = clr_busy || (accept && operation == rlg_pkg::OP_WRITE
                                && 32'(entry_index) < REGIONS);
  assign wr_addr = clr_busy ? clr_addr : AW'(entry_index);
  assign wr_data = clr_busy ? rlg_pkg::ENTRY_DEFAULT
                            : {entry_black, entry_gamma_code, entry_white};
  assign rd_addr = AW'(region_label - 16'd1);

  always_ff @(posedge clk) begin
    if (wr_en) table_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (adv) rd_data <= table_mem[rd_addr];
  end

  // stage 1: table read in flight
  logic       s1_valid;
  logic [7:0] s1_src;
  logic [7:0] s1_est;
  logic       s1_use_tab;
  logic       s1_oor;
  logic [1:0] s1_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept && operation == rlg_pkg::OP_PROCESS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_src     <= source_pixel;
      s1_est     <= estimate_pixel;
      s1_use_tab <= region_label != 16'd0 && 32'(region_label) <= REGIONS;
      s1_oor     <= 32'(region_label) > REGIONS;
      s1_mode    <= mode;
    end
  end

  // stage 2: levels, special cases, gamma constant
  logic [23:0]    ent;
  logic [7:0]     black;
  logic [7:0]     white;
  logic [8:0]     gx;
  logic [7:0]     d;
  rlg_pkg::side_t s2_side_next;
  rlg_pkg::side_t s2_side;
  logic [7:0]     s2_num;
  logic [7:0]     s2_den;

  assign ent   = s1_use_tab ? rd_data : rlg_pkg::ENTRY_DEFAULT;
  assign black = ent[23:16];
  assign white = ent[7:0];
  assign gx    = {1'b0, ent[15:8]} + 9'd128;
  assign d     = (s1_src > s1_est) ? s1_src - s1_est : 8'd0;

  always_comb begin
    s2_side_next.valid  = s1_valid;
    s2_side_next.forced = 1'b1;
    s2_side_next.fval   = 8'd0;
    s2_side_next.degen  = 1'b0;
    s2_side_next.oor    = 1'b0;
    // (x*65536 + 127) / 255 with x = code + 128, since 65536 = 257*255 + 1
    s2_side_next.g      = 17'({gx, 8'd0}) + 17'(gx) + 17'd1 + 17'(gx == 9'd383);
    case (s1_mode)
      rlg_pkg::MODE_SOURCE: begin
        s2_side_next.fval = s1_src;
      end
      rlg_pkg::MODE_ESTIMATE: begin
        s2_side_next.fval = s1_est;
      end
      default: begin
        s2_side_next.oor = s1_oor;
        if (white <= black) begin
          s2_side_next.degen = 1'b1;
          s2_side_next.fval  = (d > black) ? 8'd255 : 8'd0;
        end else if (d <= black) begin
          s2_side_next.fval = 8'd0;
        end else if (d - black >= white - black) begin
          s2_side_next.fval = 8'd255;
        end else begin
          s2_side_next.forced = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.valid <= 1'b0;
    end else if (adv) begin
      s2_side.valid <= s2_side_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side.forced <= s2_side_next.forced;
      s2_side.fval   <= s2_side_next.fval;
      s2_side.degen  <= s2_side_next.degen;
      s2_side.oor    <= s2_side_next.oor;
      s2_side.g      <= s2_side_next.g;
      s2_num         <= d - black;
      s2_den         <= white - black;
    end
  end

  // ratio, log, gamma product, exp
  rlg_pkg::side_t div_side;
  logic [15:0]    ratio;
  rlg_pkg::side_t log_side;
  logic [20:0]    mag;
  rlg_pkg::side_t pw_side;
  logic [20:0]    pw;
  logic [37:0]    pw_prod;

  rlg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .side_in  (s2_side),
    .num      (s2_num),
    .den      (s2_den),
    .side_out (div_side),
    .quot     (ratio)
  );

  rlg_log u_log (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .side_in  (div_side),
    .ratio    (ratio),
    .side_out (log_side),
    .mag      (mag)
  );

  assign pw_prod = mag * log_side.g;

  always_ff @(posedge clk) begin
    if (rst) begin
      pw_side.valid <= 1'b0;
    end else if (adv) begin
      pw_side.valid <= log_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pw_side.forced <= log_side.forced;
      pw_side.fval   <= log_side.fval;
      pw_side.degen  <= log_side.degen;
      pw_side.oor    <= log_side.oor;
      pw_side.g      <= log_side.g;
      pw             <= pw_prod[36:16];
    end
  end

  rlg_exp u_exp (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .side_in (pw_side),
    .p       (pw),
    .valid   (out_valid),
    .pixel   (pixel_out),
    .degen   (degenerate_levels),
    .oor     (label_out_of_range)
  );

  a_degen_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate_levels |-> pixel_out == 8'd0 || pixel_out == 8'd255)
    else $error("degenerate levels gave a mid-range pixel");

  a_pass_no_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode == rlg_pkg::MODE_SOURCE || mode == rlg_pkg::MODE_ESTIMATE)
      |-> !degenerate_levels && !label_out_of_range)
    else $error("flag set on a pass-through beat");

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s1_valid && !s2_side.valid)
    else $error("item in flight during table clearing");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(s2_side) && $stable(pw))
    else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire
